### design/blpg_pkg.sv
// Package for the Bresenham line pixel generator.
// Holds coordinate widths, operation codes, item structs and the line state type.
// No dependencies.
package blpg_pkg;

  localparam int COORD_BITS = 12;
  // error stays within about [-2*max, 2*max] of a coordinate difference
  localparam int ERR_BITS   = COORD_BITS + 3;
  localparam int COLOR_BITS = 32;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic                  operation;
    coord_t                x_start;
    coord_t                y_start;
    coord_t                x_end;
    coord_t                y_end;
    logic [COLOR_BITS-1:0] line_color;
  } in_item_t;

  typedef struct packed {
    logic                  pixel_valid;
    coord_t                pixel_x;
    coord_t                pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last_pixel;
  } out_item_t;

  typedef struct packed {
    coord_t                cur_x;
    coord_t                cur_y;
    coord_t                major_stop;
    logic [ERR_BITS-1:0]   error_term;
    coord_t                abs_dx;
    coord_t                abs_dy;
    logic                  y_major;
    logic                  minor_increments;
    logic [COLOR_BITS-1:0] held_color;
    logic                  line_active;
  } line_state_t;

endpackage

### design/blpg_step.sv
// Step logic of the line generator: line setup on start, one Bresenham
// step on advance, and the pixel result. Purely combinational.
// Depends on blpg_pkg.
module blpg_step (
  input  blpg_pkg::in_item_t    item_i,
  input  blpg_pkg::line_state_t state_i,
  output blpg_pkg::line_state_t state_o,
  output blpg_pkg::out_item_t   result_o
);
  import blpg_pkg::*;

  logic signed [COORD_BITS:0]   dx, dy, diff_step;
  coord_t                       adx, ady;
  logic                         dx_neg, dy_neg;
  logic signed [ERR_BITS-1:0]   err;
  line_state_t                  nxt;
  coord_t                       major;
  logic                         last;
  logic                         emit;

  assign dx     = $signed({1'b0, item_i.x_end}) - $signed({1'b0, item_i.x_start});
  assign dy     = $signed({1'b0, item_i.y_end}) - $signed({1'b0, item_i.y_start});
  assign dx_neg = dx[COORD_BITS];
  assign dy_neg = dy[COORD_BITS];
  assign adx    = dx_neg ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
  assign ady    = dy_neg ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
  assign err    = $signed(state_i.error_term);

  // minor delta - major delta for the diagonal step, doubled where it is added, sign kept in the top bit
  assign diff_step = state_i.y_major
                   ? $signed({1'b0, state_i.abs_dx}) - $signed({1'b0, state_i.abs_dy})
                   : $signed({1'b0, state_i.abs_dy}) - $signed({1'b0, state_i.abs_dx});

  always_comb begin
    nxt = state_i;
    case (item_i.operation)
      OP_START: begin
        nxt.abs_dx           = adx;
        nxt.abs_dy           = ady;
        nxt.minor_increments = (dx_neg && dy_neg) ||
                               (!dx_neg && dx != '0 && !dy_neg && dy != '0);
        nxt.held_color       = item_i.line_color;
        nxt.line_active      = 1'b1;
        if (ady <= adx) begin
          nxt.y_major = 1'b0;
          if (!dx_neg) begin
            nxt.cur_x = item_i.x_start; nxt.cur_y = item_i.y_start;
            nxt.major_stop = item_i.x_end;
          end else begin
            nxt.cur_x = item_i.x_end; nxt.cur_y = item_i.y_end;
            nxt.major_stop = item_i.x_start;
          end
          nxt.error_term = {2'b00, ady, 1'b0} - {3'b000, adx};
        end else begin
          nxt.y_major = 1'b1;
          if (!dy_neg) begin
            nxt.cur_x = item_i.x_start; nxt.cur_y = item_i.y_start;
            nxt.major_stop = item_i.y_end;
          end else begin
            nxt.cur_x = item_i.x_end; nxt.cur_y = item_i.y_end;
            nxt.major_stop = item_i.y_start;
          end
          nxt.error_term = {2'b00, adx, 1'b0} - {3'b000, ady};
        end
      end
      OP_ADVANCE: begin
        if (state_i.line_active) begin
          if (!state_i.y_major) begin
            nxt.cur_x = state_i.cur_x + 1'b1;
            if (err < 0) begin
              nxt.error_term = state_i.error_term + {2'b00, state_i.abs_dy, 1'b0};
            end else begin
              nxt.cur_y = state_i.minor_increments ? state_i.cur_y + 1'b1
                                                   : state_i.cur_y - 1'b1;
              nxt.error_term = state_i.error_term +
                               {diff_step[COORD_BITS], diff_step, 1'b0};
            end
          end else begin
            nxt.cur_y = state_i.cur_y + 1'b1;
            if (err <= 0) begin
              nxt.error_term = state_i.error_term + {2'b00, state_i.abs_dx, 1'b0};
            end else begin
              nxt.cur_x = state_i.minor_increments ? state_i.cur_x + 1'b1
                                                   : state_i.cur_x - 1'b1;
              nxt.error_term = state_i.error_term +
                               {diff_step[COORD_BITS], diff_step, 1'b0};
            end
          end
        end
      end
      default: begin
        nxt = state_i;
      end
    endcase
  end

  // a pixel comes out on start, or on advance while a line is running
  assign emit  = (item_i.operation == OP_START) || state_i.line_active;
  assign major = nxt.y_major ? nxt.cur_y : nxt.cur_x;
  assign last  = (major == nxt.major_stop);

  always_comb begin
    state_o = nxt;
    if (emit) begin
      state_o.line_active = !last;
    end
  end

  always_comb begin
    result_o = '0;
    if (emit) begin
      result_o.pixel_valid = 1'b1;
      result_o.pixel_x     = nxt.cur_x;
      result_o.pixel_y     = nxt.cur_y;
      result_o.pixel_color = nxt.held_color;
      result_o.last_pixel  = last;
    end
  end

endmodule

### design/bresenham_line_pixel_generator_unit.sv
// Bresenham line pixel generator, top level.
// Pipeline: an accepted item is held in the input register, blpg_step works on it
// combinationally, and its pixel is held in the result register. Throughput: one item per
// cycle unless the output stalls; the line state loop closes through one error add/compare.
// Reset: asynchronous, clears both pipeline valids and all line state (no line active).
// Depends on blpg_pkg and blpg_step.
module bresenham_line_pixel_generator_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  blpg_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output blpg_pkg::out_item_t out_item_o
);
  import blpg_pkg::*;

  logic        in_valid_q;
  in_item_t    in_q;
  logic        out_valid_q;
  out_item_t   out_q;
  line_state_t state_q, state_d;
  out_item_t   result;
  logic        out_free, fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || fire;

  blpg_step u_step (
    .item_i   (in_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
    if (fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### dv/bresenham_line_pixel_generator_unit_tb.sv
// Self-checking testbench for bresenham_line_pixel_generator_unit.
// Directed and random line draws go through a valid/ready driver and monitor and are
// checked against a behavioral line walker. Depends on blpg_pkg and the unit RTL.
`timescale 1ns / 100ps

module bresenham_line_pixel_generator_unit_tb;
  import blpg_pkg::*;

  localparam int WATCHDOG_CYCLES = 1000;
  localparam int HOLD_CYCLES     = 80;
  localparam int PHASE_ITEMS     = 64;
  localparam int MAX_COORD       = (1 << COORD_BITS) - 1;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  in_item_t  in_item = '0;
  logic      out_ready = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  in_item_t  pending_items[$];
  out_item_t expected_pixels[$];

  // idle and stall rates, in percent, for the current phase
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  int n_errors = 0;
  int n_starts = 0;
  int n_advances = 0;
  int n_pixels = 0;
  int n_blank = 0;
  int n_lines_done = 0;
  int quiet_cycles = 0;

  // line walker state
  coord_t          walk_x, walk_y, walk_stop;
  int              walk_err, walk_adx, walk_ady;
  bit              walk_ymajor, walk_up;
  bit              walk_active = 1'b0;
  logic [COLOR_BITS-1:0] walk_color;

  bresenham_line_pixel_generator_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_item_o (out_item_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic out_item_t next_pixel(input in_item_t it);
    out_item_t px;
    int dx, dy;
    px = '0;
    if (it.operation == OP_START) begin
      dx = int'(it.x_end) - int'(it.x_start);
      dy = int'(it.y_end) - int'(it.y_start);
      walk_adx = (dx < 0) ? -dx : dx;
      walk_ady = (dy < 0) ? -dy : dy;
      walk_up = (dx < 0 && dy < 0) || (dx > 0 && dy > 0);
      walk_color = it.line_color;
      if (walk_ady <= walk_adx) begin
        walk_ymajor = 1'b0;
        if (dx >= 0) begin
          walk_x = it.x_start; walk_y = it.y_start; walk_stop = it.x_end;
        end else begin
          walk_x = it.x_end; walk_y = it.y_end; walk_stop = it.x_start;
        end
        walk_err = 2 * walk_ady - walk_adx;
      end else begin
        walk_ymajor = 1'b1;
        if (dy >= 0) begin
          walk_x = it.x_start; walk_y = it.y_start; walk_stop = it.y_end;
        end else begin
          walk_x = it.x_end; walk_y = it.y_end; walk_stop = it.y_start;
        end
        walk_err = 2 * walk_adx - walk_ady;
      end
    end else if (!walk_active) begin
      return px;
    end else if (!walk_ymajor) begin
      walk_x = walk_x + 1'b1;
      if (walk_err < 0) begin
        walk_err += 2 * walk_ady;
      end else begin
        walk_y = walk_up ? walk_y + 1'b1 : walk_y - 1'b1;
        walk_err += 2 * (walk_ady - walk_adx);
      end
    end else begin
      // y-major steps the minor axis only on a strictly positive error
      walk_y = walk_y + 1'b1;
      if (walk_err <= 0) begin
        walk_err += 2 * walk_adx;
      end else begin
        walk_x = walk_up ? walk_x + 1'b1 : walk_x - 1'b1;
        walk_err += 2 * (walk_adx - walk_ady);
      end
    end
    px.pixel_valid = 1'b1;
    px.pixel_x     = walk_x;
    px.pixel_y     = walk_y;
    px.pixel_color = walk_color;
    px.last_pixel  = ((walk_ymajor ? walk_y : walk_x) == walk_stop);
    walk_active    = !px.last_pixel;
    return px;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] MISMATCH %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
    n_errors++;
  endtask

  task automatic push_start(input coord_t x1, input coord_t y1, input coord_t x2,
                            input coord_t y2, input logic [COLOR_BITS-1:0] color);
    in_item_t it;
    it.operation  = OP_START;
    it.x_start    = x1;
    it.y_start    = y1;
    it.x_end      = x2;
    it.y_end      = y2;
    it.line_color = color;
    pending_items.push_back(it);
  endtask

  // advance items carry random, ignored endpoint and color fields
  task automatic push_advances(input int n);
    in_item_t it;
    repeat (n) begin
      it.operation  = OP_ADVANCE;
      it.x_start    = coord_t'($urandom_range(MAX_COORD));
      it.y_start    = coord_t'($urandom_range(MAX_COORD));
      it.x_end      = coord_t'($urandom_range(MAX_COORD));
      it.y_end      = coord_t'($urandom_range(MAX_COORD));
      it.line_color = $urandom;
      pending_items.push_back(it);
    end
  endtask

  function automatic coord_t near_coord(input coord_t c);
    int v;
    v = int'(c) + $urandom_range(48) - 24;
    if (v < 0) v = 0;
    if (v > MAX_COORD) v = MAX_COORD;
    return coord_t'(v);
  endfunction

  task automatic push_line_seq();
    coord_t x1, y1, x2, y2;
    int span, yspan, adv, pick;
    x1 = coord_t'($urandom_range(MAX_COORD));
    y1 = coord_t'($urandom_range(MAX_COORD));
    pick = $urandom_range(99);
    if (pick < 8) begin
      // noise: stray advances, mostly on an idle block
      push_advances($urandom_range(1, 3));
      return;
    end
    if (pick < 18) begin
      // long line, dropped after a few pixels by the next start
      x2 = coord_t'($urandom_range(MAX_COORD));
      y2 = coord_t'($urandom_range(MAX_COORD));
      push_start(x1, y1, x2, y2, $urandom);
      push_advances($urandom_range(0, 6));
      return;
    end
    x2 = near_coord(x1);
    y2 = near_coord(y1);
    if ($urandom_range(9) == 0) y2 = y1;
    else if ($urandom_range(9) == 0) x2 = x1;
    span  = (x2 > x1) ? int'(x2) - int'(x1) : int'(x1) - int'(x2);
    yspan = (y2 > y1) ? int'(y2) - int'(y1) : int'(y1) - int'(y2);
    if (yspan > span) span = yspan;
    if ($urandom_range(4) == 0) adv = $urandom_range(span);
    else adv = span + $urandom_range(2);
    push_start(x1, y1, x2, y2, $urandom);
    push_advances(adv);
  endtask

  task automatic drain_pending();
    while (pending_items.size() != 0) @(negedge clk_i);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready_o) begin
      if (in_valid) begin
        expected_pixels.push_back(next_pixel(in_item));
        if (in_item.operation == OP_START) n_starts++;
        else n_advances++;
      end
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_item  <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off during the pressure phase
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin : monitor
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result with nothing pending", longint'(out_item_o), longint'(0));
      end else begin
        want = expected_pixels.pop_front();
        if (out_item_o.pixel_valid !== want.pixel_valid)
          report_mismatch("pixel_valid", longint'(out_item_o.pixel_valid),
                          longint'(want.pixel_valid));
        if (out_item_o.pixel_x !== want.pixel_x)
          report_mismatch("pixel_x", longint'(out_item_o.pixel_x), longint'(want.pixel_x));
        if (out_item_o.pixel_y !== want.pixel_y)
          report_mismatch("pixel_y", longint'(out_item_o.pixel_y), longint'(want.pixel_y));
        if (out_item_o.pixel_color !== want.pixel_color)
          report_mismatch("pixel_color", longint'(out_item_o.pixel_color),
                          longint'(want.pixel_color));
        if (out_item_o.last_pixel !== want.last_pixel)
          report_mismatch("last_pixel", longint'(out_item_o.last_pixel),
                          longint'(want.last_pixel));
        if (want.pixel_valid) n_pixels++;
        else n_blank++;
        if (want.last_pixel) n_lines_done++;
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("timeout: no item moved for %0d cycles", WATCHDOG_CYCLES);
        $display("bresenham_line_pixel_generator_unit verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: idle advance, single points, extremes, all directions, restart
    push_advances(1);
    push_start('0, '0, '0, '0, '0);
    push_advances(1);
    push_start(coord_t'(MAX_COORD), coord_t'(MAX_COORD), coord_t'(MAX_COORD),
               coord_t'(MAX_COORD), 32'hffff_ffff);
    push_start('0, '0, coord_t'(MAX_COORD), coord_t'(MAX_COORD), 32'ha5a5_5a5a);
    push_advances(2);
    push_start(coord_t'(MAX_COORD), '0, '0, coord_t'(MAX_COORD), 32'h5a5a_a5a5);
    push_advances(2);
    push_start(12'd3, 12'd7, 12'd0, 12'd2, 32'h1234_5678);
    push_advances(6);
    push_start(12'd5, 12'd5, 12'd9, 12'd6, 32'h8765_4321);
    push_advances(4);
    push_start(12'd2, 12'd9, 12'd4, 12'd1, 32'hdead_beef);
    push_advances(3);
    drain_pending();

    send_idle_pct = 0;  stall_pct = 0;
    while (pending_items.size() < PHASE_ITEMS) push_line_seq();
    drain_pending();
    send_idle_pct = 63; stall_pct = 0;
    while (pending_items.size() < PHASE_ITEMS) push_line_seq();
    drain_pending();
    send_idle_pct = 0;  stall_pct = 63;
    while (pending_items.size() < PHASE_ITEMS) push_line_seq();
    drain_pending();
    send_idle_pct = 13; stall_pct = 13;
    while (pending_items.size() < PHASE_ITEMS) push_line_seq();
    drain_pending();
    // back-pressure: sender keeps offering while the receiver holds off
    send_idle_pct = 0;  stall_pct = 0;
    while (pending_items.size() < PHASE_ITEMS) push_line_seq();
    hold_req = 1'b1;
    drain_pending();

    while (in_valid || expected_pixels.size() != 0) @(negedge clk_i);
    repeat (6) @(posedge clk_i);

    $display("items: %0d starts, %0d advances; results: %0d pixels, %0d blank, %0d lines ended",
             n_starts, n_advances, n_pixels, n_blank, n_lines_done);
    $display("ran free-flowing, sender-gap, receiver-stall, mixed and back-pressure phases");
    if (n_errors == 0) begin
      $display("bresenham_line_pixel_generator_unit verification clean");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("bresenham_line_pixel_generator_unit verification failed");
    end
    $finish;
  end

endmodule

### sim.f
design/blpg_pkg.sv
design/blpg_step.sv
design/bresenham_line_pixel_generator_unit.sv
dv/bresenham_line_pixel_generator_unit_tb.sv
